[design/dcm_pkg.sv]
// Shared types, constants and helpers for the differential crossbar MVM.
// No dependencies; dcm_cell, dcm_ctrl and the top level use this package.
`timescale 1ns / 1ps
package dcm_pkg;

    localparam int ROWS  = 16;
    localparam int COLS  = 16;
    localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CW    = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int RCW   = $clog2(ROWS + 1);
    localparam int CNT_W = $clog2(((ROWS > COLS + 2) ? ROWS : COLS + 2) + 1);
    localparam int ACC_W = 36;
    localparam int PRD_W = 33;

    typedef enum logic [1:0] {
        CMD_INIT  = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_APPLY = 2'd2,
        CMD_SCALE = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        CFG_GMAX = 2'd0,
        CFG_GMIN = 2'd1,
        CFG_VMIN = 2'd2,
        CFG_VMAX = 2'd3
    } t_cfg_idx;

    // Command token handed from cell to cell. For apply, gp holds the voltage.
    typedef struct packed {
        logic          vld;
        t_cmd          op;
        logic [RW-1:0] row;
        logic [CW-1:0] col;
        logic [15:0]   gp;
        logic [15:0]   gn;
        logic [16:0]   s;
        logic [15:0]   eg;
    } t_token;

    typedef struct packed {
        logic ld;   // capture net currents, clear accumulators
        logic sh;   // shift result chain toward column 0
    } t_res_ctl;

    function automatic logic signed [ACC_W-1:0] sat36(input logic signed [ACC_W:0] x);
        logic signed [ACC_W-1:0] r;
        if (x[ACC_W] != x[ACC_W-1]) begin
            r = x[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            r = x[ACC_W-1:0];
        end
        return r;
    endfunction

endpackage

[design/dcm_in_if.sv]
// Input request channel of the crossbar MVM: valid/ready plus command payload.
// Depends on nothing.
`timescale 1ns / 1ps
interface dcm_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic [3:0]         row;
    logic [3:0]         col;
    logic signed [17:0] weight;
    logic signed [15:0] voltage;
    logic               last_row;
    logic signed [17:0] scale;

    modport source (output valid, cmd, row, col, weight, voltage, last_row, scale,
                    input ready);
    modport sink   (input valid, cmd, row, col, weight, voltage, last_row, scale,
                    output ready);
endinterface

[design/dcm_out_if.sv]
// Result channel of the crossbar MVM: valid/ready plus one column result.
// Depends on nothing.
`timescale 1ns / 1ps
interface dcm_out_if;
    logic               valid;
    logic               ready;
    logic [3:0]         column;
    logic signed [35:0] net_current;
    logic               last;

    modport source (output valid, column, net_current, last, input ready);
    modport sink   (input valid, column, net_current, last, output ready);
endinterface

[design/dcm_cell.sv]
// One column cell: the column's conductance pairs, its two accumulators and
// one stage of the result shift chain. Depends on dcm_pkg.
`timescale 1ns / 1ps
module dcm_cell (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  dcm_pkg::t_token                i_tok,
    output dcm_pkg::t_token                o_tok,
    input  dcm_pkg::t_res_ctl              i_ctl,
    input  logic signed [dcm_pkg::ACC_W-1:0] i_res_next,
    input  logic                           i_res_vld_next,
    output logic signed [dcm_pkg::ACC_W-1:0] o_res,
    output logic                           o_res_vld
);

    logic [15:0] r_gp [dcm_pkg::ROWS];
    logic [15:0] r_gn [dcm_pkg::ROWS];
    logic signed [dcm_pkg::ACC_W-1:0] r_pacc, r_nacc, r_res;
    logic signed [dcm_pkg::PRD_W-1:0] r_pp, r_pn;
    logic        r_pv, r_res_vld;
    dcm_pkg::t_token r_tok, n_tok;

    logic [15:0] w_gp_rd, w_gn_rd, w_gp_sc, w_gn_sc;
    logic [32:0] w_ps, w_ns;
    logic signed [dcm_pkg::ACC_W-1:0] w_net;

    assign w_gp_rd = r_gp[i_tok.row];
    assign w_gn_rd = r_gn[i_tok.row];

    always_comb begin
        w_ps = 33'(w_gp_rd) * 33'(i_tok.s) + 33'd32768;
        w_ns = 33'(w_gn_rd) * 33'(i_tok.s) + 33'd32768;
        w_gp_sc = (w_ps[31:16] > i_tok.eg) ? i_tok.eg : w_ps[31:16];
        w_gn_sc = (w_ns[31:16] > i_tok.eg) ? i_tok.eg : w_ns[31:16];
        n_tok = i_tok;
        n_tok.col = i_tok.col - 1'b1;   // the addressed cell sees col == 0
    end

    assign w_net = dcm_pkg::sat36($signed({r_pacc[dcm_pkg::ACC_W-1], r_pacc})
                                - $signed({r_nacc[dcm_pkg::ACC_W-1], r_nacc}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < dcm_pkg::ROWS; i++) begin
                r_gp[i] <= '0;
                r_gn[i] <= '0;
            end
            r_pacc    <= '0;
            r_nacc    <= '0;
            r_pv      <= 1'b0;
            r_res_vld <= 1'b0;
            r_tok     <= '0;
        end else begin
            r_tok <= n_tok;
            r_pv  <= i_tok.vld && (i_tok.op == dcm_pkg::CMD_APPLY);
            if (i_tok.vld) begin
                case (i_tok.op)
                    dcm_pkg::CMD_INIT: begin
                        r_gp[i_tok.row] <= i_tok.gp;
                        r_gn[i_tok.row] <= i_tok.gn;
                    end
                    dcm_pkg::CMD_LOAD: begin
                        if (i_tok.col == '0) begin
                            r_gp[i_tok.row] <= i_tok.gp;
                            r_gn[i_tok.row] <= i_tok.gn;
                        end
                    end
                    dcm_pkg::CMD_SCALE: begin
                        r_gp[i_tok.row] <= w_gp_sc;
                        r_gn[i_tok.row] <= w_gn_sc;
                    end
                    dcm_pkg::CMD_APPLY: begin
                        // products land in r_pp/r_pn, summed next cycle
                    end
                    default: begin
                    end
                endcase
            end
            if (i_ctl.ld) begin
                r_pacc    <= '0;
                r_nacc    <= '0;
                r_res_vld <= 1'b1;
            end else begin
                if (r_pv) begin
                    r_pacc <= dcm_pkg::sat36($signed({r_pacc[dcm_pkg::ACC_W-1], r_pacc})
                                             + 37'(r_pp));
                    r_nacc <= dcm_pkg::sat36($signed({r_nacc[dcm_pkg::ACC_W-1], r_nacc})
                                             + 37'(r_pn));
                end
                if (i_ctl.sh) begin
                    r_res_vld <= i_res_vld_next;
                end
            end
        end
    end

    // products and result data carry no reset
    always_ff @(posedge i_clk) begin
        r_pp <= $signed(i_tok.gp) * $signed({1'b0, w_gp_rd});
        r_pn <= $signed(i_tok.gp) * $signed({1'b0, w_gn_rd});
        if (i_ctl.ld) begin
            r_res <= w_net;
        end else if (i_ctl.sh) begin
            r_res <= i_res_next;
        end
    end

    assign o_tok     = r_tok;
    assign o_res     = r_res;
    assign o_res_vld = r_res_vld;

endmodule

[design/dcm_ctrl.sv]
// Command sequencer: takes a request, does the weight/scale arithmetic and
// feeds command tokens into the cell chain. Depends on dcm_pkg and dcm_in_if.
`timescale 1ns / 1ps
module dcm_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    dcm_in_if.sink               i_in,
    input  logic [15:0]          i_g_max,
    input  logic [15:0]          i_g_min,
    input  logic signed [15:0]   i_v_min,
    input  logic signed [15:0]   i_v_max,
    input  logic                 i_res_empty,
    output dcm_pkg::t_token      o_tok,
    output logic                 o_ld
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_PREP  = 5'b00010,
        S_ISSUE = 5'b00100,
        S_DRAIN = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    dcm_pkg::t_cmd r_cmd;
    logic [3:0]         r_row, r_col;
    logic signed [17:0] r_w, r_s_in;
    logic signed [15:0] r_v;
    logic               r_last, r_ok;
    logic [16:0]        r_s;
    logic [15:0]        r_eg, r_pv, r_nv;
    logic [dcm_pkg::CNT_W-1:0] r_cnt;
    logic [dcm_pkg::RCW-1:0]   r_rows;
    dcm_pkg::t_token    r_tok, n_tok;

    logic signed [17:0] w_wc, w_sc;
    logic signed [18:0] w_a, w_b;
    logic [34:0]        w_pp, w_np;
    logic [33:0]        w_eg;
    logic signed [15:0] w_v;
    logic               w_acc;

    assign w_acc = i_in.valid && i_in.ready;

    always_comb begin
        w_wc = (r_w > 18'sd65536) ? 18'sd65536 : ((r_w < -18'sd65536) ? -18'sd65536 : r_w);
        w_a  = 19'sd65536 + 19'(w_wc);
        w_b  = 19'sd65536 - 19'(w_wc);
        w_pp = 35'(w_a[17:0]) * 35'(i_g_max) + 35'd65536;
        w_np = 35'(w_b[17:0]) * 35'(i_g_max) + 35'd65536;
        w_sc = (r_s_in < 18'sd0) ? 18'sd0 : ((r_s_in > 18'sd65536) ? 18'sd65536 : r_s_in);
        w_eg = 34'(i_g_max) * 34'(w_sc[16:0]) + 34'd32768;
        w_v  = (r_v < i_v_min) ? i_v_min : r_v;
        w_v  = (w_v > i_v_max) ? i_v_max : w_v;
    end

    always_comb begin
        n_state = r_state;
        n_tok   = '0;
        n_tok.op  = r_cmd;
        n_tok.row = dcm_pkg::RW'(r_cnt);
        n_tok.col = dcm_pkg::CW'(r_col);
        n_tok.s   = r_s;
        n_tok.eg  = r_eg;
        n_tok.gp  = r_pv;
        n_tok.gn  = r_nv;
        o_ld    = 1'b0;
        case (r_state)
            S_IDLE:  if (w_acc) n_state = S_PREP;
            S_PREP:  n_state = S_ISSUE;
            S_ISSUE: begin
                case (r_cmd)
                    dcm_pkg::CMD_INIT, dcm_pkg::CMD_SCALE: begin
                        n_tok.vld = 1'b1;
                        if (r_cnt == dcm_pkg::CNT_W'(dcm_pkg::ROWS - 1)) n_state = S_DRAIN;
                    end
                    dcm_pkg::CMD_LOAD: begin
                        n_tok.vld = r_ok;
                        n_tok.row = dcm_pkg::RW'(r_row);
                        n_state   = S_DRAIN;
                    end
                    default: begin
                        n_tok.vld = r_ok;
                        n_tok.row = dcm_pkg::RW'(r_rows);
                        n_state   = S_DRAIN;
                    end
                endcase
            end
            S_DRAIN: begin
                if (r_cnt == dcm_pkg::CNT_W'(dcm_pkg::COLS + 1)) begin
                    n_state = (r_cmd == dcm_pkg::CMD_APPLY && r_last) ? S_EMIT : S_IDLE;
                end
            end
            S_EMIT: begin
                if (i_res_empty) begin
                    o_ld    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tok   <= '0;
            r_cnt   <= '0;
            r_rows  <= '0;
            r_eg    <= 16'hFFFF;
        end else begin
            r_state <= n_state;
            r_tok   <= n_tok;
            if (r_state == S_PREP) begin
                r_cnt <= '0;
                case (r_cmd)
                    dcm_pkg::CMD_INIT:  r_eg <= i_g_max;
                    dcm_pkg::CMD_LOAD:  if (r_ok) r_eg <= i_g_max;
                    dcm_pkg::CMD_SCALE: r_eg <= w_eg[31:16];
                    default: begin
                    end
                endcase
            end else if (r_state == S_ISSUE) begin
                r_cnt <= (n_state == S_DRAIN) ? '0 : r_cnt + 1'b1;
                if (r_cmd == dcm_pkg::CMD_APPLY && r_ok) r_rows <= r_rows + 1'b1;
            end else if (r_state == S_DRAIN) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (o_ld) begin
                r_rows <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_cmd  <= dcm_pkg::t_cmd'(i_in.cmd);
            r_row  <= i_in.row;
            r_col  <= i_in.col;
            r_w    <= i_in.weight;
            r_v    <= i_in.voltage;
            r_last <= i_in.last_row;
            r_s_in <= i_in.scale;
        end
        if (r_state == S_PREP) begin
            r_s <= w_sc[16:0];
            case (r_cmd)
                dcm_pkg::CMD_INIT: begin
                    r_pv <= i_g_min;
                    r_nv <= i_g_min;
                end
                dcm_pkg::CMD_LOAD: begin
                    r_pv <= w_pp[32:17];
                    r_nv <= w_np[32:17];
                    r_ok <= (int'(r_row) < dcm_pkg::ROWS) && (int'(r_col) < dcm_pkg::COLS);
                end
                dcm_pkg::CMD_APPLY: begin
                    r_pv <= w_v;
                    r_nv <= w_v;
                    r_ok <= (int'(r_rows) < dcm_pkg::ROWS);
                end
                default: begin
                    r_pv <= r_pv;
                    r_nv <= r_nv;
                end
            endcase
        end
    end

    assign i_in.ready = (r_state == S_IDLE);
    assign o_tok      = r_tok;

endmodule

[design/differential_crossbar_mvm.sv]
// Top level of the differential crossbar MVM: configuration registers, the
// sequencer and the chain of column cells. Depends on dcm_pkg, dcm_in_if,
// dcm_out_if, dcm_ctrl and dcm_cell.
//
// Usage: requests enter on i_in (valid/ready), one at a time; ready is high
// only while no request is in work. Each request walks a token down a chain
// of COLS cells, one cell per cycle, each cell owning one column.
//   init, scale : one token per row of the array
//   load, apply : one token
// An apply with last_row set then copies all column results into the
// result chain and clears the accumulators; results leave o_out one per
// cycle while ready, column 0 first, last set on the final column. The next
// request is taken while results still drain; a later last_row waits until
// the chain is empty, so a stalled receiver only holds up that emit step.
// Configuration is written on i_cfg_we/i_cfg_idx/i_cfg_data while idle.
// Reset (synchronous, active low) restores default registers, zeroes all
// conductances and accumulators and empties the result chain.
`timescale 1ns / 1ps
module differential_crossbar_mvm (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dcm_in_if.sink      i_in,
    dcm_out_if.source   o_out,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    logic [15:0]        r_g_max, r_g_min;
    logic signed [15:0] r_v_min, r_v_max;
    logic [dcm_pkg::CW-1:0] r_col_out;

    dcm_pkg::t_token   w_tok [dcm_pkg::COLS+1];
    logic signed [dcm_pkg::ACC_W-1:0] w_res [dcm_pkg::COLS+1];
    logic              w_rv  [dcm_pkg::COLS+1];
    dcm_pkg::t_res_ctl w_ctl;
    logic              w_ld, w_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_max <= 16'hFFFF;
            r_g_min <= 16'h0000;
            r_v_min <= 16'sh8000;
            r_v_max <= 16'sh7FFF;
        end else if (i_cfg_we) begin
            case (dcm_pkg::t_cfg_idx'(i_cfg_idx))
                dcm_pkg::CFG_GMAX: r_g_max <= i_cfg_data;
                dcm_pkg::CFG_GMIN: r_g_min <= i_cfg_data;
                dcm_pkg::CFG_VMIN: r_v_min <= i_cfg_data;
                dcm_pkg::CFG_VMAX: r_v_max <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    dcm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_g_max     (r_g_max),
        .i_g_min     (r_g_min),
        .i_v_min     (r_v_min),
        .i_v_max     (r_v_max),
        .i_res_empty (!w_rv[0]),
        .o_tok       (w_tok[0]),
        .o_ld        (w_ld)
    );

    assign w_sh     = o_out.valid && o_out.ready;
    assign w_ctl.ld = w_ld;
    assign w_ctl.sh = w_sh;
    assign w_res[dcm_pkg::COLS] = '0;
    assign w_rv[dcm_pkg::COLS]  = 1'b0;

    for (genvar g = 0; g < dcm_pkg::COLS; g++) begin : g_cell
        dcm_cell u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_tok          (w_tok[g]),
            .o_tok          (w_tok[g+1]),
            .i_ctl          (w_ctl),
            .i_res_next     (w_res[g+1]),
            .i_res_vld_next (w_rv[g+1]),
            .o_res          (w_res[g]),
            .o_res_vld      (w_rv[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_out <= '0;
        end else if (w_sh) begin
            r_col_out <= o_out.last ? '0 : r_col_out + 1'b1;
        end
    end

    assign o_out.valid       = w_rv[0];
    assign o_out.net_current = w_res[0];
    assign o_out.column      = 4'(r_col_out);
    assign o_out.last        = (r_col_out == dcm_pkg::CW'(dcm_pkg::COLS - 1));

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("request accepted while another is in work");

    a_first_column: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> (o_out.column == 4'd0))
        else $error("result burst does not start at column 0");

    a_burst_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.last) |=> !o_out.valid)
        else $error("result after final column");

endmodule
